[hdl/dq_pkg.sv]
`default_nettype none

package dq_pkg;

    localparam int DATA_W = 32;

    localparam logic [2:0] CMD_QUERY      = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_POP_BACK   = 3'd4;

    // Value shown for a missing front, back or popped entry.
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic pop_failed;
        logic push_dropped;
        logic front_from_ram;
        logic back_from_ram;
    } dq_status_t;

endpackage

`default_nettype wire

[hdl/dq_ram.sv]
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/dq_ctrl.sv]
`default_nettype none

module dq_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [2:0]                 command,
    input  wire logic signed [DATA_W-1:0]   value,
    input  wire logic signed [DATA_W-1:0]   rd_data,
    output logic                            ram_we,
    output logic [$clog2(DEPTH)-1:0]        ram_waddr,
    output logic signed [DATA_W-1:0]        ram_wdata,
    output logic                            ram_re,
    output logic [$clog2(DEPTH)-1:0]        ram_raddr,
    output logic signed [DATA_W-1:0]        popped,
    output dq_status_t                      status,
    output logic [$clog2(DEPTH+1)-1:0]      count_new,
    output logic signed [DATA_W-1:0]        front_new,
    output logic signed [DATA_W-1:0]        back_new
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic signed [DATA_W-1:0]  front_reg, front_next;
    logic signed [DATA_W-1:0]  back_reg, back_next;
    logic                      front_load_reg, front_load_next;
    logic                      back_load_reg, back_load_next;

    logic signed [DATA_W-1:0]  cur_front, cur_back;
    logic [AW-1:0]             tail_pos, tail_m2_pos, head_inc, head_dec;
    logic                      full, empty;

    // The sum of two ring offsets stays below twice the depth.
    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] sum);
        logic [SW-1:0] r;
        r = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
        return r[AW-1:0];
    endfunction

    // A front or back entry refilled by the last pop arrives from the RAM's read register in the cycle after that pop.
    assign cur_front = front_load_reg ? rd_data : front_reg;
    assign cur_back  = back_load_reg  ? rd_data : back_reg;

    assign full        = (count_reg == CW'(DEPTH));
    assign empty       = (count_reg == '0);
    assign tail_pos    = wrap(SW'(head_reg) + SW'(count_reg));
    assign tail_m2_pos = wrap(SW'(head_reg) + SW'(count_reg) - SW'(2));
    assign head_inc    = wrap(SW'(head_reg) + SW'(1));
    assign head_dec    = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = cur_front;
        back_next       = cur_back;
        front_load_next = 1'b0;
        back_load_next  = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = tail_pos;
        ram_wdata       = value;
        ram_re          = 1'b0;
        ram_raddr       = head_inc;
        popped          = EMPTY_VALUE;
        status          = '0;
        if (accept)
        begin
            case (command)
                CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status.push_dropped = 1'b1;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        count_next = count_reg + CW'(1);
                        ram_we     = 1'b1;
                        ram_waddr  = head_dec;
                        front_next = value;
                        if (empty)
                        begin
                            back_next = value;
                        end
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status.push_dropped = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        ram_we     = 1'b1;
                        ram_waddr  = tail_pos;
                        back_next  = value;
                        if (empty)
                        begin
                            front_next = value;
                        end
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status.pop_failed = 1'b1;
                    end
                    else
                    begin
                        popped     = cur_front;
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                        if (count_reg != CW'(1))
                        begin
                            ram_re          = 1'b1;
                            ram_raddr       = head_inc;
                            front_load_next = 1'b1;
                        end
                    end
                end
                CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status.pop_failed = 1'b1;
                    end
                    else
                    begin
                        popped     = cur_back;
                        count_next = count_reg - CW'(1);
                        if (count_reg != CW'(1))
                        begin
                            ram_re         = 1'b1;
                            ram_raddr      = tail_m2_pos;
                            back_load_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        status.front_from_ram = front_load_next;
        status.back_from_ram  = back_load_next;
    end

    assign count_new = count_next;
    assign front_new = front_next;
    assign back_new  = back_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            front_load_reg <= 1'b0;
            back_load_reg  <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            front_load_reg <= front_load_next;
            back_load_reg  <= back_load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        back_reg  <= back_next;
    end

endmodule

`default_nettype wire

[hdl/double_ended_queue.sv]
// Channel   Handshake                Payload
// input     in_valid / in_ready      command, value
// output    out_valid / out_ready    popped_value, pop_failed, push_dropped,
//                                    count, is_empty, front_value, back_value
//
// One item is taken every cycle unless a result is stalled; its result is offered in the next cycle.
// A pop refills the front or back entry through the RAM's registered read
// port, and that value is forwarded from the read register, so the refill
// is ready in the same cycle as the result register.
// Reset clears the head, the count and the handshake state; the RAM is not cleared.
// A stalled result holds, and a new item is taken only when no result is pending or in the cycle the result is taken.
`default_nettype none

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    command,
    input  wire logic signed [DATA_W-1:0]      value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [DATA_W-1:0]           popped_value,
    output logic                               pop_failed,
    output logic                               push_dropped,
    output logic [$clog2(DEPTH+1)-1:0]         count,
    output logic                               is_empty,
    output logic signed [DATA_W-1:0]           front_value,
    output logic signed [DATA_W-1:0]           back_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                      accept;
    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic signed [DATA_W-1:0]  ram_wdata, rd_data;
    logic signed [DATA_W-1:0]  popped, front_new, back_new;
    logic [CW-1:0]             count_new;
    dq_status_t                status;

    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  out_popped_reg, out_front_reg, out_back_reg;
    logic [CW-1:0]             out_count_reg;
    dq_status_t                out_status_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    dq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .value     (value),
        .rd_data   (rd_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .popped    (popped),
        .status    (status),
        .count_new (count_new),
        .front_new (front_new),
        .back_new  (back_new)
    );

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr   (ram_raddr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
        end
        else if (accept)
        begin
            out_valid_reg  <= out_valid_next;
            out_status_reg <= status;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_popped_reg <= popped;
            out_count_reg  <= count_new;
            out_front_reg  <= front_new;
            out_back_reg   <= back_new;
        end
    end

    // The read register holds until the next accepted pop, so a stalled result stays intact.
    assign out_valid    = out_valid_reg;
    assign popped_value = out_popped_reg;
    assign pop_failed   = out_status_reg.pop_failed;
    assign push_dropped = out_status_reg.push_dropped;
    assign count        = out_count_reg;
    assign is_empty     = (out_count_reg == '0);
    assign front_value  = is_empty ? EMPTY_VALUE :
                          (out_status_reg.front_from_ram ? rd_data : out_front_reg);
    assign back_value   = is_empty ? EMPTY_VALUE :
                          (out_status_reg.back_from_ram ? rd_data : out_back_reg);

endmodule

`default_nettype wire

[hdl/dq_chk.sv]
`default_nettype none

module dq_chk
    import dq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic signed [DATA_W-1:0]      popped_value,
    input  wire logic                          pop_failed,
    input  wire logic                          push_dropped,
    input  wire logic [$clog2(DEPTH+1)-1:0]    count,
    input  wire logic                          is_empty,
    input  wire logic signed [DATA_W-1:0]      front_value,
    input  wire logic signed [DATA_W-1:0]      back_value
);

    localparam int CW = $clog2(DEPTH + 1);

    // A stalled result must not change, including the RAM-forwarded fields.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(popped_value) && $stable(count)
            && $stable(front_value) && $stable(back_value))
        else $error("result changed while stalled");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> front_value == EMPTY_VALUE && back_value == EMPTY_VALUE)
        else $error("empty deque shows a front or back value");

    a_pop_failed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pop_failed |-> popped_value == EMPTY_VALUE && is_empty && count == '0)
        else $error("failed pop with a value or a nonzero count");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && push_dropped |-> count == CW'(DEPTH) && !pop_failed)
        else $error("push dropped while not full");

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pop_failed || push_dropped) |-> $countones({pop_failed, push_dropped}) == 1
            && (push_dropped || is_empty))
        else $error("inconsistent result flags");

endmodule

bind double_ended_queue dq_chk #(.DEPTH(DEPTH)) u_dq_chk (.*);

`default_nettype wire
